FILE: rtl/bdq_pkg.sv
// Shared constants, command codes and cell control type for the bounded deque.
`default_nettype none
package bdq_pkg;

  localparam int DEPTH_DEF = 16;
  localparam int VAL_W     = 32;

  localparam logic [2:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [2:0] CMD_PUSH_BACK  = 3'd1;
  localparam logic [2:0] CMD_SORTED     = 3'd2;
  localparam logic [2:0] CMD_POP_FRONT  = 3'd3;
  localparam logic [2:0] CMD_POP_BACK   = 3'd4;
  localparam logic [2:0] CMD_READ_ALL   = 3'd5;

  localparam logic [1:0] STAT_OK    = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  localparam logic [2:0] MODE_HOLD       = 3'd0;
  localparam logic [2:0] MODE_PUSH_FRONT = 3'd1;
  localparam logic [2:0] MODE_PUSH_BACK  = 3'd2;
  localparam logic [2:0] MODE_SORTED     = 3'd3;
  localparam logic [2:0] MODE_ROTATE     = 3'd4;

  typedef struct packed {
    logic [2:0]       mode;
    logic [VAL_W-1:0] value;
  } cell_ctrl_t;

endpackage
`default_nettype wire

FILE: rtl/bdq_cell.sv
// One storage cell of the deque chain: holds one entry and shifts with its neighbors.
`default_nettype none
module bdq_cell
  import bdq_pkg::*;
#(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  wire logic             clk,
  input  wire cell_ctrl_t       ctrl,
  input  wire logic [CNT_W-1:0] count,
  input  wire logic [VAL_W-1:0] left_data,
  input  wire logic [VAL_W-1:0] right_data,
  input  wire logic [VAL_W-1:0] head_data,
  input  wire logic             found_in,
  output logic                  found_out,
  output logic [VAL_W-1:0]      data_out
);

  logic [VAL_W-1:0] data_r;
  logic [VAL_W-1:0] data_nxt;
  logic             stop;
  logic             is_last;
  logic             v_le_self;
  logic             self_gt_v;

  assign v_le_self = $signed(ctrl.value) <= $signed(data_r);
  assign self_gt_v = $signed(data_r) > $signed(ctrl.value);
  assign is_last   = (count == CNT_W'(IDX + 1));

  // The insertion point is the first cell that raises stop; cells past it shift right.
  always_comb begin
    stop = 1'b0;
    case (ctrl.mode)
      MODE_PUSH_FRONT: stop = (IDX == 0);
      MODE_PUSH_BACK:  stop = (count == CNT_W'(IDX));
      MODE_SORTED: begin
        if (IDX == 0) begin
          stop = (count == '0) || v_le_self;
        end else begin
          stop = (count == CNT_W'(IDX)) || ((count > CNT_W'(IDX)) && self_gt_v);
        end
      end
      default: stop = 1'b0;
    endcase
  end

  assign found_out = found_in | stop;

  always_comb begin
    data_nxt = data_r;
    case (ctrl.mode) inside
      MODE_PUSH_FRONT, MODE_PUSH_BACK, MODE_SORTED: begin
        if (found_in) begin
          data_nxt = left_data;
        end else if (stop) begin
          data_nxt = ctrl.value;
        end
      end
      MODE_ROTATE: begin
        data_nxt = is_last ? head_data : right_data;
      end
      default: data_nxt = data_r;
    endcase
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_out = data_r;

endmodule
`default_nettype wire

FILE: rtl/bounded_deque_sorted_insert_unit.sv
// Top level of the bounded deque with sorted insert: command control and the cell chain.
//
//   channel  | ports                                       | handshake
//   ---------+---------------------------------------------+---------------------------
//   request  | start, busy, in_cmd, in_value               | taken when start && !busy
//   result   | out_valid, out_value_res, out_status, out_last | one-cycle strobe, no stall
//
// Push, insert and pop results show in the cycle after the request is taken,
// and a new request can be taken in the very next cycle.
// A read-out of N entries rotates the cell chain once per cycle through cell 0, so busy
// stays high until the last entry has rotated out, and the results stream out back to back.
// Reset clears the entry count and the control state; entry contents are not cleared.
// The result channel cannot stall, so nothing ever waits on the receiver.
`default_nettype none
module bounded_deque_sorted_insert_unit
  import bdq_pkg::*;
#(
  parameter int DEPTH = DEPTH_DEF
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  output logic                   busy,
  input  wire logic [2:0]        in_cmd,
  input  wire logic [VAL_W-1:0]  in_value,
  output logic                   out_valid,
  output logic [VAL_W-1:0]       out_value_res,
  output logic [1:0]             out_status,
  output logic                   out_last
);

  localparam int CNT_W = $clog2(DEPTH + 1);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_READ = 1'b1;

  logic             state_r, state_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic [CNT_W-1:0] rd_cnt_r, rd_cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [VAL_W-1:0] out_value_r, out_value_nxt;
  logic [1:0]       out_status_r, out_status_nxt;
  logic             out_last_r, out_last_nxt;

  logic             accept;
  logic             full;
  logic             empty;
  cell_ctrl_t       ctrl;
  logic [VAL_W-1:0] head;
  logic [VAL_W-1:0] tail;
  logic [VAL_W-1:0] cell_data [DEPTH];
  logic             found     [DEPTH+1];

  assign busy   = (state_r == ST_READ);
  assign accept = start && !busy;
  assign full   = (count_r == CNT_W'(DEPTH));
  assign empty  = (count_r == '0);

  // Cell chain
  assign found[0] = 1'b0;
  assign head     = cell_data[0];

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    bdq_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count_r),
      .left_data  ((i == 0) ? in_value : cell_data[(i == 0) ? 0 : i - 1]),
      .right_data ((i == DEPTH - 1) ? head : cell_data[(i == DEPTH - 1) ? i : i + 1]),
      .head_data  (head),
      .found_in   (found[i]),
      .found_out  (found[i+1]),
      .data_out   (cell_data[i])
    );
  end

  // The back entry is picked by the one cell whose index matches count - 1.
  always_comb begin
    tail = '0;
    for (int i = 0; i < DEPTH; i++) begin
      if (count_r == CNT_W'(i + 1)) begin
        tail = tail | cell_data[i];
      end
    end
  end

  always_comb begin
    state_nxt      = state_r;
    count_nxt      = count_r;
    rd_cnt_nxt     = rd_cnt_r;
    out_valid_nxt  = 1'b0;
    out_value_nxt  = '0;
    out_status_nxt = STAT_OK;
    out_last_nxt   = 1'b1;
    ctrl.mode      = MODE_HOLD;
    ctrl.value     = in_value;

    unique case (state_r)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_cmd) inside
            CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED: begin
              out_valid_nxt = 1'b1;
              if (full) begin
                out_status_nxt = STAT_FULL;
              end else begin
                count_nxt = count_r + CNT_W'(1);
                case (in_cmd)
                  CMD_PUSH_FRONT: ctrl.mode = MODE_PUSH_FRONT;
                  CMD_PUSH_BACK:  ctrl.mode = MODE_PUSH_BACK;
                  default:        ctrl.mode = MODE_SORTED;
                endcase
              end
            end
            CMD_POP_FRONT: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                // Rotating left drops the head; the copy lands beyond the new count.
                ctrl.mode     = MODE_ROTATE;
                out_value_nxt = head;
                count_nxt     = count_r - CNT_W'(1);
              end
            end
            CMD_POP_BACK: begin
              out_valid_nxt = 1'b1;
              if (empty) begin
                out_status_nxt = STAT_EMPTY;
              end else begin
                out_value_nxt = tail;
                count_nxt     = count_r - CNT_W'(1);
              end
            end
            CMD_READ_ALL: begin
              if (empty) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = STAT_EMPTY;
              end else begin
                state_nxt  = ST_READ;
                rd_cnt_nxt = '0;
              end
            end
            default: begin
              out_valid_nxt = 1'b0;
            end
          endcase
        end
      end
      ST_READ: begin
        // A full rotation of count steps leaves the list as it was.
        ctrl.mode     = MODE_ROTATE;
        out_valid_nxt = 1'b1;
        out_value_nxt = head;
        out_last_nxt  = (rd_cnt_r == count_r - CNT_W'(1));
        rd_cnt_nxt    = rd_cnt_r + CNT_W'(1);
        if (out_last_nxt) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      count_r     <= '0;
      rd_cnt_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      rd_cnt_r    <= rd_cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_value_r  <= out_value_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_valid     = out_valid_r;
  assign out_value_res = out_value_r;
  assign out_status    = out_status_r;
  assign out_last      = out_last_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count exceeds capacity");

  a_read_nonempty : assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !empty)
    else $error("read-out running on an empty list");

  a_read_last : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && rd_cnt_r == count_r - CNT_W'(1)) |=> (out_valid && out_last && !busy))
    else $error("read-out did not end with a last result");

  a_full_drop : assert property (@(posedge clk) disable iff (!rst_n)
    (accept && full && (in_cmd == CMD_PUSH_FRONT || in_cmd == CMD_PUSH_BACK ||
     in_cmd == CMD_SORTED)) |=> (out_valid && out_status == STAT_FULL && $stable(count_r)))
    else $error("push into a full list was not dropped");

  a_read_midstream : assert property (@(posedge clk) disable iff (!rst_n)
    (busy && rd_cnt_r != count_r - CNT_W'(1)) |=> (out_valid && !out_last))
    else $error("read-out result flagged last too early");

endmodule
`default_nettype wire

FILE: test/tb.sv
// Self-checking testbench for the bounded deque with sorted insert.
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bdq_pkg::*;

  localparam logic [2:0] CMD_UNDEF_A = 3'd6;
  localparam logic [2:0] CMD_UNDEF_B = 3'd7;
  localparam int         RAND_ITEMS  = 448;

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [1:0]       status;
    logic             last;
  } deque_result_t;

  typedef struct packed {
    logic [2:0]       cmd;
    logic [VAL_W-1:0] value;
    int               reps;
    bit               typed;
    deque_result_t    want;
  } step_row_t;

  logic             clk      = 1'b0;
  logic             rst_n    = 1'b0;
  logic             start    = 1'b0;
  logic [2:0]       in_cmd   = 3'd0;
  logic [VAL_W-1:0] in_value = '0;
  logic             busy;
  logic             out_valid;
  logic [VAL_W-1:0] out_value_res;
  logic [1:0]       out_status;
  logic             out_last;

  // Shadow copy of the list, front at index 0.
  logic signed [VAL_W-1:0] shadow_list [DEPTH_DEF];
  int                      shadow_count;
  deque_result_t           owed_results [$];

  int idle_pct;
  int err_count;
  int n_items;
  int n_results;
  int n_full;
  int n_empty;
  int n_readouts;

  step_row_t directed_rows [25];

  bounded_deque_sorted_insert_unit dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_cmd       (in_cmd),
    .in_value     (in_value),
    .out_valid    (out_valid),
    .out_value_res(out_value_res),
    .out_status   (out_status),
    .out_last     (out_last)
  );

  always #10 clk = ~clk;

  function automatic deque_result_t mk_result(logic [VAL_W-1:0] v, logic [1:0] st,
                                              logic lst);
    deque_result_t r;
    r.value  = v;
    r.status = st;
    r.last   = lst;
    return r;
  endfunction

  // Applies one request to the shadow list and, if emit is set, queues what it owes.
  task automatic shadow_apply(input logic [2:0] cmd, input logic [VAL_W-1:0] value,
                              input bit emit);
    int pos;
    int i;
    logic signed [VAL_W-1:0] sv;
    logic signed [VAL_W-1:0] popped;
    sv = value;
    case (cmd) inside
      CMD_PUSH_FRONT, CMD_PUSH_BACK, CMD_SORTED: begin
        if (shadow_count >= DEPTH_DEF) begin
          if (emit) owed_results.push_back(mk_result('0, STAT_FULL, 1'b1));
        end else begin
          if (cmd == CMD_PUSH_FRONT) begin
            pos = 0;
          end else if (cmd == CMD_PUSH_BACK) begin
            pos = shadow_count;
          end else if (shadow_count == 0 || sv <= shadow_list[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < shadow_count && shadow_list[pos] <= sv) pos++;
          end
          for (i = shadow_count; i > pos; i--) shadow_list[i] = shadow_list[i-1];
          shadow_list[pos] = sv;
          shadow_count++;
          if (emit) owed_results.push_back(mk_result('0, STAT_OK, 1'b1));
        end
      end
      CMD_POP_FRONT: begin
        if (shadow_count == 0) begin
          if (emit) owed_results.push_back(mk_result('0, STAT_EMPTY, 1'b1));
        end else begin
          popped = shadow_list[0];
          for (i = 1; i < shadow_count; i++) shadow_list[i-1] = shadow_list[i];
          shadow_count--;
          if (emit) owed_results.push_back(mk_result(popped, STAT_OK, 1'b1));
        end
      end
      CMD_POP_BACK: begin
        if (shadow_count == 0) begin
          if (emit) owed_results.push_back(mk_result('0, STAT_EMPTY, 1'b1));
        end else begin
          shadow_count--;
          if (emit) owed_results.push_back(mk_result(shadow_list[shadow_count], STAT_OK, 1'b1));
        end
      end
      CMD_READ_ALL: begin
        n_readouts++;
        if (shadow_count == 0) begin
          if (emit) owed_results.push_back(mk_result('0, STAT_EMPTY, 1'b1));
        end else if (emit) begin
          for (i = 0; i < shadow_count; i++)
            owed_results.push_back(mk_result(shadow_list[i], STAT_OK,
                                              (i + 1 == shadow_count)));
        end
      end
      default: begin
      end
    endcase
  endtask

  // Drives one request and waits until the block takes it.
  task automatic send_request(input logic [2:0] cmd, input logic [VAL_W-1:0] value,
                              input bit typed, input deque_result_t want);
    int gap;
    gap = 0;
    if (idle_pct != 0 && $urandom_range(99) < idle_pct) gap = $urandom_range(1, 3);
    if (gap != 0) begin
      // Junk on the request ports while start is low must be ignored.
      start    <= 1'b0;
      in_cmd   <= 3'($urandom);
      in_value <= $urandom;
      repeat (gap) @(posedge clk);
    end
    start    <= 1'b1;
    in_cmd   <= cmd;
    in_value <= value;
    @(posedge clk);
    while (busy) @(posedge clk);
    shadow_apply(cmd, value, !typed);
    if (typed) owed_results.push_back(want);
    n_items++;
  endtask

  function automatic logic [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(99);
    if (r < 40) return $urandom;
    if (r < 75) return VAL_W'($signed($urandom_range(16)) - 8);
    if (r < 90) begin
      case ($urandom_range(5))
        0: return 32'h8000_0000;
        1: return 32'h7fff_ffff;
        2: return 32'hffff_ffff;
        3: return 32'h0000_0000;
        4: return 32'h8000_0001;
        default: return 32'h7fff_fffe;
      endcase
    end
    return VAL_W'($signed($urandom_range(2000)) - 1000);
  endfunction

  function automatic logic [2:0] pick_cmd(bit filling);
    int r;
    int push_w;
    push_w = filling ? 67 : 20;
    r = $urandom_range(99);
    if (r < 3) return ($urandom_range(1) != 0) ? CMD_UNDEF_A : CMD_UNDEF_B;
    if (r < 13) return CMD_READ_ALL;
    if (r < 13 + push_w) begin
      case ($urandom_range(3))
        0: return CMD_PUSH_FRONT;
        1: return CMD_PUSH_BACK;
        default: return CMD_SORTED;
      endcase
    end
    return ($urandom_range(1) != 0) ? CMD_POP_FRONT : CMD_POP_BACK;
  endfunction

  // Every strobed result is matched against the oldest owed one.
  always @(posedge clk) begin
    deque_result_t exp_r;
    if (rst_n && out_valid) begin
      n_results++;
      if (out_status == STAT_FULL) n_full++;
      if (out_status == STAT_EMPTY) n_empty++;
      if (owed_results.size() == 0) begin
        $error("unexpected result: value_res %h status %0d last %0d",
               out_value_res, out_status, out_last);
        err_count++;
      end else begin
        exp_r = owed_results.pop_front();
        if (out_value_res !== exp_r.value) begin
          $error("value_res: expected %h, got %h", exp_r.value, out_value_res);
          err_count++;
        end
        if (out_status !== exp_r.status) begin
          $error("status: expected %0d, got %0d", exp_r.status, out_status);
          err_count++;
        end
        if (out_last !== exp_r.last) begin
          $error("last: expected %0d, got %0d", exp_r.last, out_last);
          err_count++;
        end
      end
    end
  end

  initial begin
    #5ms;
    $display("tb: errors");
    $finish;
  end

  initial begin
    int row;
    int k;
    int ph;
    bit filling;
    deque_result_t none_r;
    none_r = mk_result('0, STAT_OK, 1'b0);
    err_count    = 0;
    n_items      = 0;
    n_results    = 0;
    n_full       = 0;
    n_empty      = 0;
    n_readouts   = 0;
    shadow_count = 0;
    idle_pct     = 0;
    for (k = 0; k < DEPTH_DEF; k++) shadow_list[k] = '0;

    directed_rows[0]  = '{CMD_POP_FRONT,  32'h0, 1, 1'b1, mk_result('0, STAT_EMPTY, 1'b1)};
    directed_rows[1]  = '{CMD_POP_BACK,   32'h0, 1, 1'b1, mk_result('0, STAT_EMPTY, 1'b1)};
    directed_rows[2]  = '{CMD_READ_ALL,   32'h0, 1, 1'b1, mk_result('0, STAT_EMPTY, 1'b1)};
    directed_rows[3]  = '{CMD_UNDEF_A, 32'ha5a5_a5a5, 1, 1'b0, none_r};
    directed_rows[4]  = '{CMD_PUSH_BACK, 32'h7fff_ffff, 1, 1'b1, mk_result('0, STAT_OK, 1'b1)};
    directed_rows[5]  = '{CMD_POP_BACK, 32'h0, 1, 1'b1,
                          mk_result(32'h7fff_ffff, STAT_OK, 1'b1)};
    directed_rows[6]  = '{CMD_PUSH_FRONT, 32'h8000_0000, 1, 1'b1,
                          mk_result('0, STAT_OK, 1'b1)};
    directed_rows[7]  = '{CMD_POP_FRONT, 32'h0, 1, 1'b1,
                          mk_result(32'h8000_0000, STAT_OK, 1'b1)};
    directed_rows[8]  = '{CMD_SORTED, 32'd5, 1, 1'b1, mk_result('0, STAT_OK, 1'b1)};
    // Below the head goes in front; an equal value goes after the ones already there.
    directed_rows[9]  = '{CMD_SORTED, 32'hffff_fffd, 1, 1'b0, none_r};
    directed_rows[10] = '{CMD_SORTED, 32'd5, 1, 1'b0, none_r};
    directed_rows[11] = '{CMD_SORTED, 32'd100, 1, 1'b0, none_r};
    directed_rows[12] = '{CMD_SORTED, 32'd4, 1, 1'b0, none_r};
    directed_rows[13] = '{CMD_PUSH_FRONT, 32'hffff_ffff, 1, 1'b0, none_r};
    directed_rows[14] = '{CMD_READ_ALL, 32'h0, 1, 1'b0, none_r};
    directed_rows[15] = '{CMD_UNDEF_B, 32'h0, 1, 1'b0, none_r};
    directed_rows[16] = '{CMD_PUSH_BACK, 32'h42, 10, 1'b0, none_r};
    directed_rows[17] = '{CMD_PUSH_BACK, 32'h1, 1, 1'b1, mk_result('0, STAT_FULL, 1'b1)};
    directed_rows[18] = '{CMD_PUSH_FRONT, 32'h2, 1, 1'b1, mk_result('0, STAT_FULL, 1'b1)};
    directed_rows[19] = '{CMD_SORTED, 32'h3, 1, 1'b1, mk_result('0, STAT_FULL, 1'b1)};
    directed_rows[20] = '{CMD_READ_ALL, 32'h0, 1, 1'b0, none_r};
    directed_rows[21] = '{CMD_POP_FRONT, 32'h0, 1, 1'b0, none_r};
    directed_rows[22] = '{CMD_SORTED, 32'h8000_0000, 1, 1'b0, none_r};
    directed_rows[23] = '{CMD_POP_BACK, 32'h0, 1, 1'b0, none_r};
    directed_rows[24] = '{CMD_SORTED, 32'h7fff_ffff, 1, 1'b0, none_r};

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    for (row = 0; row < 25; row++)
      for (k = 0; k < directed_rows[row].reps; k++)
        send_request(directed_rows[row].cmd, directed_rows[row].value,
                     directed_rows[row].typed, directed_rows[row].want);

    // Random part in four idling phases; the fill/drain tide walks the list between
    // empty and full.
    filling = 1'b1;
    for (ph = 0; ph < 4; ph++) begin
      case (ph)
        0: idle_pct = 0;
        1: idle_pct = 51;
        2: idle_pct = 25;
        default: idle_pct = 0;
      endcase
      for (k = 0; k < RAND_ITEMS / 4; k++) begin
        if ($urandom_range(24) == 0) filling = !filling;
        send_request(pick_cmd(filling), pick_value(), 1'b0, none_r);
      end
    end

    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("summary: %0d requests (%0d read-outs), %0d results checked",
             n_items, n_readouts, n_results);
    $display("summary: %0d full drops, %0d empty responses, %0d mismatches",
             n_full, n_empty, err_count);
    if (err_count == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
